// ----- rtl/dns_name_label_encoder_defines.svh -----
// assertion helpers used by the checker file
`ifndef DNS_NAME_LABEL_ENCODER_DEFINES_SVH
`define DNS_NAME_LABEL_ENCODER_DEFINES_SVH

// same-cycle implication
`define DNLE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DNLE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/dnle_pkg.sv -----
package dnle_pkg;

   // label buffer limit, one flush is a length byte plus at most this many bytes
   localparam int LABEL_MAX = 62;

   localparam int CHAR_W = 8;
   localparam int CNT_W  = $clog2(LABEL_MAX + 1);
   localparam int ADDR_W = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1;

   localparam logic [CHAR_W-1:0] DOT_CHAR = 8'h2E;

   typedef logic [CHAR_W-1:0] char_type;
   typedef logic [CNT_W-1:0]  count_type;
   typedef logic [ADDR_W-1:0] addr_type;

endpackage

// ----- rtl/dnle_ram.sv -----
module dnle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 62
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/dns_name_label_encoder.sv -----
// channel | direction | handshake                 | payload
// req     | in        | req_valid / req_stall     | req_name_char, req_end_of_name
// rsp     | out       | rsp_valid / rsp_stall     | rsp_wire_byte, rsp_last_of_run,
//         |           |                           | rsp_end_of_encoded_name, rsp_label_overflow
//
// an ordinary character item gives no result
// a dot item gives n + 1 results for a buffered label of n bytes
// an end item gives n + 2 results with a label, the root byte only without
// flush bytes come one per cycle while rsp_stall is low, from the label buffer ram through its single read port
// reset is synchronous and empties the label buffer count; the ram itself is not cleared
// rsp_stall freezes the output register and the flush sequencer; req_stall is high while flushing
module dns_name_label_encoder (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  dnle_pkg::char_type     req_name_char,
   input  logic                   req_end_of_name,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output dnle_pkg::char_type     rsp_wire_byte,
   output logic                   rsp_last_of_run,
   output logic                   rsp_end_of_encoded_name,
   output logic                   rsp_label_overflow
);
   import dnle_pkg::*;

   // sequencer states
   localparam logic [1:0] S_IDLE = 2'd0;   // taking characters
   localparam logic [1:0] S_LEN  = 2'd1;   // emit length byte
   localparam logic [1:0] S_DATA = 2'd2;   // replay buffered bytes
   localparam logic [1:0] S_ROOT = 2'd3;   // emit closing root byte

   logic [1:0] state_ff, state_in;
   count_type  count_ff, count_in;       // characters buffered in this label
   logic       ovf_ff, ovf_in;           // a character was dropped
   logic       end_ff, end_in;           // flush was started by an end item
   count_type  idx_ff, idx_in;           // byte being replayed

   logic       rsp_valid_ff, rsp_valid_in;
   char_type   byte_ff, byte_in;
   logic       last_ff, last_in;
   logic       endn_ff, endn_in;
   logic       lovf_ff, lovf_in;

   logic       accept;
   logic       out_free;
   logic       emit;
   count_type  idx_next;

   // label buffer ram ports
   logic       wr_en;
   logic       rd_en;
   addr_type   rd_addr;
   char_type   rd_data;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   // output register can take a new item when empty or being drained
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign idx_next  = CNT_W'(idx_ff + 1'b1);

   assign wr_en = accept && !req_end_of_name && (req_name_char != DOT_CHAR)
                  && (count_ff < CNT_W'(LABEL_MAX));

   dnle_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (LABEL_MAX)
   ) u_label_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (req_name_char),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      end_in       = end_ff;
      idx_in       = idx_ff;
      emit         = 1'b0;
      byte_in      = byte_ff;
      last_in      = last_ff;
      endn_in      = endn_ff;
      lovf_in      = lovf_ff;
      rd_en        = 1'b0;
      rd_addr      = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_end_of_name) begin
                  end_in   = 1'b1;
                  state_in = (count_ff != '0) ? S_LEN : S_ROOT;
               end else if (req_name_char == DOT_CHAR) begin
                  end_in   = 1'b0;
                  state_in = S_LEN;
               end else if (count_ff < CNT_W'(LABEL_MAX)) begin
                  count_in = CNT_W'(count_ff + 1'b1);
               end else begin
                  ovf_in = 1'b1;
               end
            end
         end
         S_LEN: begin
            if (out_free) begin
               emit    = 1'b1;
               byte_in = CHAR_W'(count_ff);
               last_in = !end_ff && (count_ff == '0);
               endn_in = 1'b0;
               lovf_in = ovf_ff;
               idx_in  = '0;
               if (count_ff != '0) begin
                  // fetch first label byte for the next cycle
                  rd_en    = 1'b1;
                  rd_addr  = '0;
                  state_in = S_DATA;
               end else begin
                  // empty label from a dot
                  count_in = '0;
                  ovf_in   = 1'b0;
                  state_in = S_IDLE;
               end
            end
         end
         S_DATA: begin
            if (out_free) begin
               emit    = 1'b1;
               byte_in = rd_data;
               endn_in = 1'b0;
               lovf_in = ovf_ff;
               if (idx_next == count_ff) begin
                  last_in  = !end_ff;
                  count_in = '0;
                  ovf_in   = 1'b0;
                  state_in = end_ff ? S_ROOT : S_IDLE;
               end else begin
                  last_in = 1'b0;
                  rd_en   = 1'b1;
                  rd_addr = idx_next[ADDR_W-1:0];
                  idx_in  = idx_next;
               end
            end
         end
         S_ROOT: begin
            if (out_free) begin
               emit     = 1'b1;
               byte_in  = '0;
               last_in  = 1'b1;
               endn_in  = 1'b1;
               lovf_in  = 1'b0;
               count_in = '0;
               ovf_in   = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         end_ff       <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         end_ff       <= end_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // output payload, loaded only when a new item goes out
   always_ff @(posedge clock) begin
      if (emit) begin
         byte_ff <= byte_in;
         last_ff <= last_in;
         endn_ff <= endn_in;
         lovf_ff <= lovf_in;
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_wire_byte           = byte_ff;
   assign rsp_last_of_run         = last_ff;
   assign rsp_end_of_encoded_name = endn_ff;
   assign rsp_label_overflow      = lovf_ff;

endmodule

// ----- rtl/dnle_checker.sv -----
`include "dns_name_label_encoder_defines.svh"

module dnle_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input dnle_pkg::char_type req_name_char,
   input logic               req_end_of_name,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input dnle_pkg::char_type rsp_wire_byte,
   input logic               rsp_last_of_run,
   input logic               rsp_end_of_encoded_name,
   input logic               rsp_label_overflow
);
   import dnle_pkg::*;

   // stalled result stays up
   `DNLE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "rsp dropped while stalled")

   // root byte is zero, closes the run and never flags overflow
   `DNLE_ASSERT_NOW(a_root_byte, clock, reset, rsp_valid && rsp_end_of_encoded_name, (rsp_wire_byte == '0) && rsp_last_of_run && !rsp_label_overflow, "bad root byte")

   // an end item always starts a flush
   `DNLE_ASSERT_NEXT(a_end_busy, clock, reset, req_valid && !req_stall && req_end_of_name, req_stall, "end item did not start flush")

   // a dot always starts a flush
   `DNLE_ASSERT_NEXT(a_dot_busy, clock, reset, req_valid && !req_stall && !req_end_of_name && (req_name_char == DOT_CHAR), req_stall, "dot did not start flush")

endmodule

bind dns_name_label_encoder dnle_checker u_dnle_checker (.*);

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps

module tb;
   import dnle_pkg::*;

   // one byte of the wire-format name as it leaves the block
   typedef struct packed {
      char_type wire_byte;
      logic     last_of_run;
      logic     end_of_encoded_name;
      logic     label_overflow;
   } wire_res;

   // one row of the directed table: a character sent reps times,
   // optionally with the first result of the item written in by hand
   typedef struct {
      char_type ch;
      logic     eon;
      int       reps;
      logic     pinned;
      wire_res  first;
   } stim_row;

   // the directed table sends 212 items, so the whole run is about 430
   localparam int RAND_ITEMS     = 220;
   localparam int WATCHDOG_LIMIT = 4000;  // far above the longest quiet stretch
   localparam int DRAIN_CYCLES   = 100;   // a full flush is a length byte, LABEL_MAX bytes and the root byte

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     req_valid = 1'b0;
   logic     req_stall;
   char_type req_name_char = '0;
   logic     req_end_of_name = 1'b0;
   logic     rsp_valid;
   logic     rsp_stall = 1'b0;
   char_type rsp_wire_byte;
   logic     rsp_last_of_run;
   logic     rsp_end_of_encoded_name;
   logic     rsp_label_overflow;

   dns_name_label_encoder dut (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_name_char           (req_name_char),
      .req_end_of_name         (req_end_of_name),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_wire_byte           (rsp_wire_byte),
      .rsp_last_of_run         (rsp_last_of_run),
      .rsp_end_of_encoded_name (rsp_end_of_encoded_name),
      .rsp_label_overflow      (rsp_label_overflow)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // predictor: a private copy of the label buffer and its flags
   // ---------------------------------------------------------------
   char_type    label_buf [LABEL_MAX];
   int unsigned label_len = 0;
   logic        label_cut = 1'b0;

   // wire bytes still owed by the block, oldest first
   wire_res     owed_bytes [$];

   int err_count       = 0;
   int items_sent      = 0;
   int bytes_checked   = 0;
   int names_closed    = 0;
   int truncated_bytes = 0;
   int idle_cycles     = 0;
   int stall_run       = 0;
   bit no_idle         = 1'b0;

   function automatic wire_res mk_res(char_type b, logic last, logic root, logic cut);
      wire_res r;
      r.wire_byte           = b;
      r.last_of_run         = last;
      r.end_of_encoded_name = root;
      r.label_overflow      = cut;
      return r;
   endfunction

   // length byte, then the buffered characters; the flag rides on all of them
   task automatic flush_label();
      owed_bytes.push_back(mk_res(char_type'(label_len), 1'b0, 1'b0, label_cut));
      for (int i = 0; i < label_len; i++)
         owed_bytes.push_back(mk_res(label_buf[addr_type'(i)], 1'b0, 1'b0, label_cut));
      label_len = 0;
      label_cut = 1'b0;
   endtask

   task automatic encode_item(char_type ch, logic eon);
      wire_res tail;
      if (eon) begin
         // end of name: flush a non-empty label, then the root byte
         if (label_len != 0)
            flush_label();
         label_len = 0;
         label_cut = 1'b0;
         owed_bytes.push_back(mk_res(8'h00, 1'b1, 1'b1, 1'b0));
      end else if (ch == DOT_CHAR) begin
         // a dot always flushes, even an empty label (lone zero length)
         flush_label();
         tail = owed_bytes.pop_back();
         tail.last_of_run = 1'b1;
         owed_bytes.push_back(tail);
      end else if (label_len < LABEL_MAX) begin
         label_buf[addr_type'(label_len)] = ch;
         label_len++;
      end else begin
         // characters past the limit are dropped and the label is marked
         label_cut = 1'b1;
      end
   endtask

   // ---------------------------------------------------------------
   // idle lengths: mostly none or short, now and then long
   // ---------------------------------------------------------------
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 40);
   endfunction

   // mostly short labels, some long ones, the exact limit and a few over it
   function automatic int pick_label_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80)
         return $urandom_range(1, 12);
      else if (r < 92)
         return $urandom_range(13, LABEL_MAX - 1);
      else if (r < 96)
         return LABEL_MAX;
      else
         return $urandom_range(LABEL_MAX + 1, LABEL_MAX + 8);
   endfunction

   function automatic char_type rand_char();
      return char_type'($urandom_range(0, 255));
   endfunction

   task automatic report_mismatch(string what, int unsigned want, int unsigned got);
      err_count++;
      $display("mismatch: %s expected %0h got %0h at %0t", what, want, got, $time);
   endtask

   // ---------------------------------------------------------------
   // sender: called at a falling edge, returns at a falling edge
   // ---------------------------------------------------------------
   task automatic send_item(char_type ch, logic eon, logic pinned, wire_res first);
      int gap;
      int idx;
      gap = no_idle ? 0 : pick_gap();
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      // expectations go in before the item is shown, so they always lead the results
      idx = owed_bytes.size();
      encode_item(ch, eon);
      if (pinned)
         owed_bytes[idx] = first;
      req_valid       = 1'b1;
      req_name_char   = ch;
      req_end_of_name = eon;
      do
         @(posedge clock);
      while (req_stall);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic hold_off();
      req_valid = 1'b0;
   endtask

   // ---------------------------------------------------------------
   // receiver stalls, changed at the falling edge
   // ---------------------------------------------------------------
   always @(negedge clock) begin
      if (stall_run != 0) begin
         stall_run--;
      end else if (no_idle) begin
         rsp_stall = 1'b0;
      end else begin
         rsp_stall = ($urandom_range(0, 2) == 0);
         stall_run = rsp_stall ? pick_gap() : int'($urandom_range(0, 8));
      end
   end

   // ---------------------------------------------------------------
   // result checker and watchdog, sampled at the rising edge
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      wire_res want;
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", idle_cycles);
            $display("tb: errors");
            $finish;
         end else if (rsp_valid && !rsp_stall) begin
            bytes_checked++;
            if (owed_bytes.size() == 0) begin
               report_mismatch("result with nothing owed, byte", 0, 32'(rsp_wire_byte));
            end else begin
               want = owed_bytes.pop_front();
               if (rsp_wire_byte !== want.wire_byte)
                  report_mismatch("wire_byte", 32'(want.wire_byte), 32'(rsp_wire_byte));
               if (rsp_last_of_run !== want.last_of_run)
                  report_mismatch("last_of_run", 32'(want.last_of_run),
                                  32'(rsp_last_of_run));
               if (rsp_end_of_encoded_name !== want.end_of_encoded_name)
                  report_mismatch("end_of_encoded_name", 32'(want.end_of_encoded_name),
                                  32'(rsp_end_of_encoded_name));
               if (rsp_label_overflow !== want.label_overflow)
                  report_mismatch("label_overflow", 32'(want.label_overflow),
                                  32'(rsp_label_overflow));
               if (want.end_of_encoded_name)
                  names_closed++;
               if (want.label_overflow)
                  truncated_bytes++;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------
   stim_row dir_rows [$];

   function automatic stim_row mk_row(char_type ch, logic eon, int reps, logic pinned,
                                      wire_res first);
      stim_row r;
      r.ch     = ch;
      r.eon    = eon;
      r.reps   = reps;
      r.pinned = pinned;
      r.first  = first;
      return r;
   endfunction

   initial begin
      wire_res  root_byte;
      wire_res  none;
      char_type ch;
      logic     eon;
      int       n;
      int       len;
      int       dir_items;
      bit       paused;

      root_byte = mk_res(8'h00, 1'b1, 1'b1, 1'b0);
      none      = '0;
      paused    = 1'b0;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // end item straight after reset: root byte only
      dir_rows.push_back(mk_row(8'h00, 1'b1, 1, 1'b1, root_byte));
      // two dots in a row, the first one leading: a lone zero length each
      dir_rows.push_back(mk_row(DOT_CHAR, 1'b0, 1, 1'b1, mk_res(8'h00, 1'b1, 1'b0, 1'b0)));
      dir_rows.push_back(mk_row(DOT_CHAR, 1'b0, 1, 1'b1, mk_res(8'h00, 1'b1, 1'b0, 1'b0)));
      // extreme character values are ordinary label bytes
      dir_rows.push_back(mk_row(8'h00, 1'b0, 1, 1'b0, none));
      dir_rows.push_back(mk_row(8'hFF, 1'b0, 1, 1'b0, none));
      dir_rows.push_back(mk_row(DOT_CHAR, 1'b0, 1, 1'b0, none));
      // trailing dot: the end item gives only the root byte
      dir_rows.push_back(mk_row(8'h00, 1'b1, 1, 1'b1, root_byte));
      // label of exactly the limit
      dir_rows.push_back(mk_row(8'h41, 1'b0, LABEL_MAX, 1'b0, none));
      dir_rows.push_back(mk_row(DOT_CHAR, 1'b0, 1, 1'b1,
                                mk_res(char_type'(LABEL_MAX), 1'b0, 1'b0, 1'b0)));
      // too long, flushed by a dot
      dir_rows.push_back(mk_row(8'h7A, 1'b0, LABEL_MAX + 8, 1'b0, none));
      dir_rows.push_back(mk_row(DOT_CHAR, 1'b0, 1, 1'b1,
                                mk_res(char_type'(LABEL_MAX), 1'b0, 1'b0, 1'b1)));
      // too long by one, flushed by the end item
      dir_rows.push_back(mk_row(8'h80, 1'b0, LABEL_MAX + 1, 1'b0, none));
      dir_rows.push_back(mk_row(8'hFF, 1'b1, 1, 1'b1,
                                mk_res(char_type'(LABEL_MAX), 1'b0, 1'b0, 1'b1)));
      // neighbors of the dot code, then an end item whose character is a dot
      dir_rows.push_back(mk_row(8'h2D, 1'b0, 1, 1'b0, none));
      dir_rows.push_back(mk_row(8'h2F, 1'b0, 1, 1'b0, none));
      dir_rows.push_back(mk_row(DOT_CHAR, 1'b1, 1, 1'b0, none));
      // one-character labels
      dir_rows.push_back(mk_row(8'h01, 1'b0, 1, 1'b0, none));
      dir_rows.push_back(mk_row(DOT_CHAR, 1'b0, 1, 1'b0, none));
      dir_rows.push_back(mk_row(8'h7F, 1'b0, 1, 1'b0, none));
      dir_rows.push_back(mk_row(8'hAA, 1'b1, 1, 1'b0, none));

      foreach (dir_rows[i]) begin
         for (int k = 0; k < dir_rows[i].reps; k++)
            send_item(dir_rows[i].ch, dir_rows[i].eon, dir_rows[i].pinned,
                      dir_rows[i].first);
      end
      dir_items = items_sent;

      // random names: mostly well-formed, with some noise mixed in
      while (items_sent - dir_items < RAND_ITEMS || !paused) begin
         // a stretch with no idling on either side
         no_idle = (items_sent - dir_items >= 60) && (items_sent - dir_items < 110);
         // once, let everything drain before sending on
         if (!paused && items_sent - dir_items >= 150) begin
            paused = 1'b1;
            hold_off();
            while (owed_bytes.size() != 0)
               @(negedge clock);
         end
         if ($urandom_range(0, 9) == 0) begin
            // noise: stray dots, stray end items, random bytes
            n = $urandom_range(1, 8);
            for (int k = 0; k < n; k++) begin
               ch  = ($urandom_range(0, 3) == 0) ? DOT_CHAR : rand_char();
               eon = ($urandom_range(0, 5) == 0);
               send_item(ch, eon, 1'b0, none);
            end
         end else begin
            n = $urandom_range(1, 4);
            for (int k = 0; k < n; k++) begin
               if ($urandom_range(0, 15) == 0)
                  send_item(DOT_CHAR, 1'b0, 1'b0, none);  // empty label
               len = pick_label_len();
               for (int j = 0; j < len; j++)
                  send_item(rand_char(), 1'b0, 1'b0, none);
               // separating dots, and now and then a trailing one
               if (k < n - 1 || $urandom_range(0, 3) == 0)
                  send_item(DOT_CHAR, 1'b0, 1'b0, none);
            end
            send_item(rand_char(), 1'b1, 1'b0, none);
         end
      end
      no_idle = 1'b0;
      hold_off();

      // wait for every owed byte, then a margin for anything extra
      while (owed_bytes.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run: %0d items sent (%0d directed), %0d bytes checked, %0d names closed",
               items_sent, dir_items, bytes_checked, names_closed);
      $display("run: %0d bytes from truncated labels, %0d mismatches",
               truncated_bytes, err_count);
      if (err_count == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

endmodule
